@@ hdl/humidity_sensor_frame_decoder_defines.svh @@
// Assertion macros for the humidity sensor frame decoder.
// Needs a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef HUMIDITY_SENSOR_FRAME_DECODER_DEFINES_SVH
`define HUMIDITY_SENSOR_FRAME_DECODER_DEFINES_SVH
`ifndef SYNTHESIS
`define HSFD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define HSFD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define HSFD_ASSERT_SAME(label, ante, cons)
`define HSFD_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hdl/hsfd_pkg.sv @@
// Shared types, constants and the CRC-8 step of the humidity sensor frame decoder.
// No dependencies.
`default_nettype none
package hsfd_pkg;

    localparam logic [7:0]  CRC_POLY          = 8'h31;
    localparam logic [7:0]  CRC_INIT          = 8'hFF;
    localparam logic [14:0] TEMP_SPAN_CENTI   = 15'd17500;
    localparam logic [15:0] TEMP_OFFSET_CENTI = 16'd4500;
    localparam logic [13:0] HUM_SPAN_CENTI    = 14'd10000;
    localparam int          QUEUE_DEPTH_DEF   = 2;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_TEMP_CRC = 2'd1;
    localparam logic [1:0] STATUS_HUM_CRC  = 2'd2;

    typedef struct packed {
        logic [15:0] raw_t;
        logic [15:0] raw_h;
        logic [1:0]  status;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_flags_t;

    // One byte through the CRC-8, MSB first.
    function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int i = 0; i < 8; i++)
        begin
            c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        end
        return c;
    endfunction

endpackage
`default_nettype wire

@@ hdl/humidity_sensor_frame_decoder.sv @@
// Top level of the humidity sensor frame decoder: byte tracker, job queue, scaling pipeline.
// Uses hsfd_pkg, hsfd_front, hsfd_queue, hsfd_scale and the assertion macro header.
//
//  channel   ports                                        transfer
//  bytes     rx_byte, frame_start, push / full            push && !full
//  results   temperature_centi, humidity_centi, status,   pop && !empty
//            empty / pop
//
// One byte is taken every cycle while the job queue has room; the sixth byte of a
// frame enters the queue and its result is formed by the multiply stage, then
// the divide-and-offset stage into the result register.
// Reset clears the frame position, CRC and the queue; no result is waiting after reset.
// A stalled result holds the pipeline; full rises once the queue fills behind it.
`default_nettype none
`include "humidity_sensor_frame_decoder_defines.svh"
module humidity_sensor_frame_decoder #(
    parameter int QUEUE_DEPTH = hsfd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire logic [7:0]        rx_byte,
    input  wire logic              frame_start,
    output logic                   empty,
    input  wire logic              pop,
    output logic signed [14:0]     temperature_centi,
    output logic        [13:0]     humidity_centi,
    output logic        [1:0]      status
);
    import hsfd_pkg::*;

    logic     take;
    logic     job_push;
    job_t     job;
    job_t     head;
    q_flags_t q_flags;
    logic     q_pop;

    assign full = q_flags.full;
    assign take = push && !q_flags.full;

    hsfd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .take        (take),
        .rx_byte     (rx_byte),
        .frame_start (frame_start),
        .job_push    (job_push),
        .job         (job)
    );

    hsfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (job_push),
        .push_job (job),
        .pop      (q_pop),
        .head     (head),
        .flags    (q_flags)
    );

    hsfd_scale u_scale (
        .clk               (clk),
        .rst_n             (rst_n),
        .head              (head),
        .q_flags           (q_flags),
        .q_pop             (q_pop),
        .pop               (pop),
        .empty             (empty),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi),
        .status            (status)
    );

    `HSFD_ASSERT_SAME(a_status_code, !empty, (status == STATUS_OK || status == STATUS_TEMP_CRC || status == STATUS_HUM_CRC))
    `HSFD_ASSERT_SAME(a_error_zeroes, !empty && status != STATUS_OK, temperature_centi == 15'sd0 && humidity_centi == 14'd0)
    `HSFD_ASSERT_SAME(a_hum_range, !empty && status == STATUS_OK, humidity_centi <= HUM_SPAN_CENTI)
    `HSFD_ASSERT_NEXT(a_queue_drains, q_flags.full && q_pop && !job_push, !q_flags.full)

endmodule
`default_nettype wire

@@ hdl/hsfd_front.sv @@
// Byte tracker: frame position, CRC check and raw value assembly.
// Uses hsfd_pkg; emits one job per complete frame.
`default_nettype none
module hsfd_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          take,
    input  wire logic [7:0]    rx_byte,
    input  wire logic          frame_start,
    output logic               job_push,
    output hsfd_pkg::job_t     job
);
    import hsfd_pkg::*;

    localparam logic [2:0] POS_T_HI  = 3'd0;
    localparam logic [2:0] POS_T_LO  = 3'd1;
    localparam logic [2:0] POS_T_CRC = 3'd2;
    localparam logic [2:0] POS_H_HI  = 3'd3;
    localparam logic [2:0] POS_H_LO  = 3'd4;
    localparam logic [2:0] POS_H_CRC = 3'd5;

    logic [2:0]  pos_reg, pos_next, pos_eff;
    logic [7:0]  crc_reg, crc_next;
    logic [15:0] raw_t_reg, raw_t_next;
    logic [15:0] raw_h_reg, raw_h_next;
    logic        tbad_reg, tbad_next;
    logic        last_byte;

    assign pos_eff   = (frame_start || pos_reg > POS_H_CRC) ? POS_T_HI : pos_reg;
    assign last_byte = (pos_eff == POS_H_CRC);

    always_comb
    begin
        crc_next   = crc_reg;
        raw_t_next = raw_t_reg;
        raw_h_next = raw_h_reg;
        tbad_next  = tbad_reg;
        unique case (pos_eff)
            POS_T_HI:
            begin
                raw_t_next = {rx_byte, 8'h00};
                crc_next   = crc8_feed(CRC_INIT, rx_byte);
            end
            POS_T_LO:
            begin
                raw_t_next = {raw_t_reg[15:8], rx_byte};
                crc_next   = crc8_feed(crc_reg, rx_byte);
            end
            POS_T_CRC:
            begin
                tbad_next = (rx_byte != crc_reg);
                crc_next  = CRC_INIT;
            end
            POS_H_HI:
            begin
                raw_h_next = {rx_byte, 8'h00};
                crc_next   = crc8_feed(CRC_INIT, rx_byte);
            end
            POS_H_LO:
            begin
                raw_h_next = {raw_h_reg[15:8], rx_byte};
                crc_next   = crc8_feed(crc_reg, rx_byte);
            end
            POS_H_CRC:
            begin
                crc_next = CRC_INIT;
            end
            default:
            begin
                crc_next = crc_reg;
            end
        endcase
        pos_next = last_byte ? POS_T_HI : pos_eff + 3'd1;
    end

    always_comb
    begin
        job.raw_t = raw_t_reg;
        job.raw_h = raw_h_reg;
        // temperature error wins over humidity error
        if (tbad_reg)
            job.status = STATUS_TEMP_CRC;
        else if (rx_byte != crc_reg)
            job.status = STATUS_HUM_CRC;
        else
            job.status = STATUS_OK;
    end

    assign job_push = take && last_byte;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= POS_T_HI;
            crc_reg   <= CRC_INIT;
            raw_t_reg <= '0;
            raw_h_reg <= '0;
            tbad_reg  <= 1'b0;
        end
        else if (take)
        begin
            pos_reg   <= pos_next;
            crc_reg   <= crc_next;
            raw_t_reg <= raw_t_next;
            raw_h_reg <= raw_h_next;
            tbad_reg  <= tbad_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/hsfd_queue.sv @@
// Short job queue between the byte tracker and the scaling pipeline.
// Uses hsfd_pkg for the job and flag types.
`default_nettype none
module hsfd_queue #(
    parameter int DEPTH = hsfd_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire hsfd_pkg::job_t push_job,
    input  wire logic          pop,
    output hsfd_pkg::job_t     head,
    output hsfd_pkg::q_flags_t flags
);
    import hsfd_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign flags.full  = (count_reg == CNT_W'(DEPTH));
    assign flags.empty = (count_reg == '0);
    assign do_push     = push && !flags.full;
    assign do_pop      = pop && !flags.empty;
    assign head        = entry_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

@@ hdl/hsfd_scale.sv @@
// Scaling pipeline: multiply, divide by full scale, offset, and the result register.
// Uses hsfd_pkg; pulls jobs from hsfd_queue.
`default_nettype none
module hsfd_scale (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hsfd_pkg::job_t     head,
    input  wire hsfd_pkg::q_flags_t q_flags,
    output logic                   q_pop,
    input  wire logic              pop,
    output logic                   empty,
    output logic signed [14:0]     temperature_centi,
    output logic        [13:0]     humidity_centi,
    output logic        [1:0]      status
);
    import hsfd_pkg::*;

    logic        s1_valid_reg;
    logic [30:0] s1_t_prod_reg;
    logic [29:0] s1_h_prod_reg;
    logic [1:0]  s1_status_reg;

    logic               out_valid_reg;
    logic signed [14:0] out_t_reg;
    logic [13:0]        out_h_reg;
    logic [1:0]         out_status_reg;

    logic        advance;
    logic [15:0] t_quot, h_quot;
    logic [15:0] t_shifted;

    // floor(x / 65535) for x below 2^31: add the high half and one, keep bits 31:16
    function automatic logic [15:0] div_full_scale(input logic [31:0] x);
        logic [31:0] s;
        s = x + {16'h0000, x[31:16]} + 32'd1;
        return s[31:16];
    endfunction

    assign advance = !out_valid_reg || pop;
    assign q_pop   = advance && !q_flags.empty;

    assign t_quot    = div_full_scale({1'b0, s1_t_prod_reg});
    assign h_quot    = div_full_scale({2'b00, s1_h_prod_reg});
    assign t_shifted = t_quot - TEMP_OFFSET_CENTI;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_t_prod_reg  <= 31'(head.raw_t) * 31'(TEMP_SPAN_CENTI);
            s1_h_prod_reg  <= 30'(head.raw_h) * 30'(HUM_SPAN_CENTI);
            s1_status_reg  <= head.status;
            out_status_reg <= s1_status_reg;
            // drop the measurement on any CRC error
            if (s1_status_reg == STATUS_OK)
            begin
                out_t_reg <= signed'(t_shifted[14:0]);
                out_h_reg <= h_quot[13:0];
            end
            else
            begin
                out_t_reg <= '0;
                out_h_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= !q_flags.empty;
            out_valid_reg <= s1_valid_reg;
        end
    end

    assign empty             = !out_valid_reg;
    assign temperature_centi = out_t_reg;
    assign humidity_centi    = out_h_reg;
    assign status            = out_status_reg;

endmodule
`default_nettype wire

@@ sim/humidity_sensor_frame_decoder_tb.sv @@
// Self-checking testbench for the humidity sensor frame decoder: byte stimulus, reading checks.
// Depends on hsfd_pkg and the humidity_sensor_frame_decoder top level; needs nothing else.
module humidity_sensor_frame_decoder_tb;

    localparam int IDLE_LIMIT     = 2000;
    localparam int HOLDOFF_CYCLES = 300;
    localparam int RANDOM_BYTES   = 1500;
    localparam int TAIL_CYCLES    = 10;

    typedef struct packed {
        logic signed [14:0] temp_centi;
        logic        [13:0] hum_centi;
        logic        [1:0]  stat;
    } reading_t;

    // Tracks the frame position and CRC of the byte stream and holds the readings still due.
    class reading_scoreboard;
        localparam int unsigned FULL_SCALE   = 65535;
        localparam int unsigned TEMP_SPAN    = 17500;
        localparam int unsigned TEMP_OFFSET  = 4500;
        localparam int unsigned HUM_SPAN     = 10000;

        bit [2:0]  position;
        bit [7:0]  crc;
        bit [15:0] raw_t;
        bit [15:0] raw_h;
        bit        t_crc_bad;
        reading_t  readings_due[$];
        int        failures;
        int        readings_checked;
        int        bytes_taken;
        int        resyncs;
        int        status_count[3];

        function new();
            position = '0;
            crc      = hsfd_pkg::CRC_INIT;
            raw_t    = '0;
            raw_h    = '0;
            t_crc_bad = 1'b0;
        endfunction

        // Bit-serial form of the CRC-8: feed the data MSB first.
        static function bit [7:0] crc_step(bit [7:0] c, bit [7:0] d);
            bit fb;
            for (int i = 7; i >= 0; i--)
            begin
                fb = c[7] ^ d[i];
                c  = {c[6:0], 1'b0};
                if (fb)
                    c = c ^ hsfd_pkg::CRC_POLY;
            end
            return c;
        endfunction

        function void note_byte(bit [7:0] b, bit fs);
            reading_t    r;
            bit [2:0]    at;
            int unsigned scaled;
            at = position;
            bytes_taken++;
            if (fs && at != 0)
                resyncs++;
            if (fs || at > 5)
                at = 0;
            case (at)
                3'd0:
                begin
                    raw_t = {b, 8'h00};
                    crc   = crc_step(hsfd_pkg::CRC_INIT, b);
                end
                3'd1:
                begin
                    raw_t[7:0] = b;
                    crc        = crc_step(crc, b);
                end
                3'd2:
                begin
                    t_crc_bad = (b != crc);
                    crc       = hsfd_pkg::CRC_INIT;
                end
                3'd3:
                begin
                    raw_h = {b, 8'h00};
                    crc   = crc_step(hsfd_pkg::CRC_INIT, b);
                end
                3'd4:
                begin
                    raw_h[7:0] = b;
                    crc        = crc_step(crc, b);
                end
                default:
                begin
                    r = '0;
                    if (t_crc_bad)
                        r.stat = hsfd_pkg::STATUS_TEMP_CRC;
                    else if (b != crc)
                        r.stat = hsfd_pkg::STATUS_HUM_CRC;
                    else
                    begin
                        r.stat       = hsfd_pkg::STATUS_OK;
                        scaled       = (int'(raw_t) * TEMP_SPAN) / FULL_SCALE;
                        r.temp_centi = 15'(scaled - TEMP_OFFSET);
                        scaled       = (int'(raw_h) * HUM_SPAN) / FULL_SCALE;
                        r.hum_centi  = 14'(scaled);
                    end
                    crc = hsfd_pkg::CRC_INIT;
                    readings_due.push_back(r);
                end
            endcase
            position = (at >= 5) ? 3'd0 : at + 3'd1;
        endfunction

        function void check_result(logic signed [14:0] t, logic [13:0] h, logic [1:0] s);
            reading_t want;
            if (readings_due.size() == 0)
            begin
                $error("reading with none due: temperature_centi %0d humidity_centi %0d status %0d",
                       t, h, s);
                failures++;
                return;
            end
            want = readings_due.pop_front();
            readings_checked++;
            if (t !== want.temp_centi)
            begin
                $error("temperature_centi: expected %0d, got %0d",
                       $signed(want.temp_centi), t);
                failures++;
            end
            if (h !== want.hum_centi)
            begin
                $error("humidity_centi: expected %0d, got %0d", want.hum_centi, h);
                failures++;
            end
            if (s !== want.stat)
            begin
                $error("status: expected %0d, got %0d", want.stat, s);
                failures++;
            end
            if (want.stat <= hsfd_pkg::STATUS_HUM_CRC)
                status_count[want.stat]++;
        endfunction

        function int pending();
            return readings_due.size();
        endfunction
    endclass

    logic                clk;
    logic                rst_n       = 1'b0;
    logic                push        = 1'b0;
    logic [7:0]          rx_byte     = 8'h00;
    logic                frame_start = 1'b0;
    logic                pop         = 1'b0;
    logic                full;
    logic                empty;
    logic signed [14:0]  temperature_centi;
    logic        [13:0]  humidity_centi;
    logic        [1:0]   status;

    reading_scoreboard sb = new();
    int burst_left   = 8;
    int idle_cycles  = 0;
    int full_stalls  = 0;

    humidity_sensor_frame_decoder u_top (
        .clk               (clk),
        .rst_n             (rst_n),
        .push              (push),
        .full              (full),
        .rx_byte           (rx_byte),
        .frame_start       (frame_start),
        .empty             (empty),
        .pop               (pop),
        .temperature_centi (temperature_centi),
        .humidity_centi    (humidity_centi),
        .status            (status)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Offer one byte until it transfers; close the burst with an idle gap when it runs out.
    task automatic send_byte(input logic [7:0] b, input logic fs);
        push        <= 1'b1;
        rx_byte     <= b;
        frame_start <= fs;
        do
            @(posedge clk);
        while (full);
        sb.note_byte(b, fs);
        burst_left--;
        if (burst_left <= 0)
        begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) == 0) ? 300 : $urandom_range(1, 24);
        end
    endtask

    task automatic send_frame(input logic [15:0] t, input logic [15:0] h, input logic fs,
                              input logic [7:0] t_flip, input logic [7:0] h_flip);
        logic [7:0] tc;
        logic [7:0] hc;
        tc = reading_scoreboard::crc_step(
                 reading_scoreboard::crc_step(hsfd_pkg::CRC_INIT, t[15:8]), t[7:0]) ^ t_flip;
        hc = reading_scoreboard::crc_step(
                 reading_scoreboard::crc_step(hsfd_pkg::CRC_INIT, h[15:8]), h[7:0]) ^ h_flip;
        send_byte(t[15:8], fs);
        send_byte(t[7:0], 1'b0);
        send_byte(tc, 1'b0);
        send_byte(h[15:8], 1'b0);
        send_byte(h[7:0], 1'b0);
        send_byte(hc, 1'b0);
    endtask

    function automatic logic [15:0] pick_raw();
        case ($urandom_range(0, 9))
            0:       return 16'h0000;
            1:       return 16'hFFFF;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // Result side: check every transfer, stall on a rotating pattern, hold off once for long.
    initial
    begin : result_side
        int  cycle;
        int  holdoff;
        bit  holdoff_done;
        bit  want;
        cycle        = 0;
        holdoff      = 0;
        holdoff_done = 1'b0;
        wait (rst_n);
        forever
        begin
            @(posedge clk);
            if (pop && !empty)
                sb.check_result(temperature_centi, humidity_centi, status);
            cycle++;
            if (!holdoff_done && sb.readings_checked >= 40)
            begin
                holdoff      = HOLDOFF_CYCLES;
                holdoff_done = 1'b1;
            end
            if (holdoff > 0)
            begin
                holdoff--;
                want = 1'b0;
            end
            else
            begin
                case ((cycle / 64) % 4)
                    0:       want = 1'b1;
                    1:       want = $urandom_range(0, 1);
                    2:       want = ($urandom_range(0, 3) == 0);
                    default: want = ($urandom_range(0, 9) != 0);
                endcase
            end
            pop <= want;
        end
    end

    // Watchdog: give up after a long run of cycles with no transfer on either side.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (push && full)
                full_stalls++;
            if ((push && !full) || (pop && !empty))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("[humidity_sensor_frame_decoder] ERROR");
                $finish;
            end
        end
    end

    initial
    begin : byte_side
        int n;
        int kind;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Scale extremes with good CRCs, then back-to-back without a start flag.
        send_frame(16'h0000, 16'hFFFF, 1'b1, 8'h00, 8'h00);
        send_frame(16'hFFFF, 16'h0000, 1'b0, 8'h00, 8'h00);
        // Both CRCs bad: the temperature error wins.
        send_frame(16'h6666, 16'h8000, 1'b0, 8'hFF, 8'h01);
        // Partial frame, dropped by a start flag; then a humidity CRC error.
        send_byte(8'hA5, 1'b0);
        send_byte(8'h5A, 1'b0);
        send_frame(16'h8000, 16'h7FFF, 1'b1, 8'h00, 8'h80);

        n = 0;
        while (n < RANDOM_BYTES)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 80)
            begin
                send_frame(pick_raw(), pick_raw(), $urandom_range(0, 1),
                           ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00,
                           ($urandom_range(0, 9) == 0) ? 8'($urandom_range(1, 255)) : 8'h00);
                n += 6;
            end
            else if (kind < 90)
            begin
                // Broken frame: a few bytes, then a new frame has to resync.
                repeat ($urandom_range(1, 5))
                begin
                    send_byte(8'($urandom_range(0, 255)), 1'b0);
                    n++;
                end
            end
            else
            begin
                repeat ($urandom_range(1, 8))
                begin
                    send_byte(8'($urandom_range(0, 255)), ($urandom_range(0, 3) == 0));
                    n++;
                end
            end
        end
        push <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (sb.pending() != 0)
        begin
            $error("%0d readings still due at the end", sb.pending());
            sb.failures++;
        end
        $display("Run covered %0d bytes (%0d start-flag resyncs), %0d readings checked:",
                 sb.bytes_taken, sb.resyncs, sb.readings_checked);
        $display("  %0d ok, %0d temperature CRC, %0d humidity CRC; %0d cycles with input stalled",
                 sb.status_count[0], sb.status_count[1], sb.status_count[2], full_stalls);
        if (sb.failures == 0)
            $display("[humidity_sensor_frame_decoder] OK");
        else
            $display("[humidity_sensor_frame_decoder] ERROR");
        $finish;
    end

endmodule
